### hw/rtl/triangle_height_interpolator_top_defines.svh
// Assertion macros for the triangle height interpolator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TRIANGLE_HEIGHT_INTERPOLATOR_TOP_DEFINES_SVH
`define TRIANGLE_HEIGHT_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define THI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thi assertion failed");

// next-cycle implication
`define THI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thi assertion failed");

`endif

### hw/rtl/thi_pkg.sv
// Shared types, constants and helpers for the triangle height interpolator.
// No dependencies.
`default_nettype none
package thi_pkg;

  localparam int COORD_W        = 32;
  localparam int EDGE_W         = 33;
  localparam int SC_W           = 15;
  localparam int SC_LIMIT       = 16383;
  localparam int SHIFT_W        = 5;
  localparam int SHIFT_MAX      = 19;
  localparam int DOT_W          = 32;
  localparam int PROD_W         = 64;
  localparam int TOL_W          = 17;
  localparam logic [TOL_W-1:0] TOL_RESET = 17'd7;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0][2:0][SC_W-1:0] sc;
    logic signed [EDGE_W-1:0]  e0y;
    logic signed [EDGE_W-1:0]  e1y;
    logic signed [COORD_W-1:0] ay;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } front_stat_t;

  // smallest right shift that brings every magnitude within the scaled range
  function automatic logic [SHIFT_W-1:0] scale_shift(input logic [EDGE_W-1:0] mag_or);
    logic [SHIFT_W-1:0] s;
    s = SHIFT_W'(SHIFT_MAX);
    for (int i = SHIFT_MAX; i >= 0; i--) begin
      if ((mag_or >> i) <= EDGE_W'(SC_LIMIT)) begin
        s = SHIFT_W'(i);
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/thi_front.sv
// Front end: edge vectors, common scale search and scaling of the nine components.
// Depends on thi_pkg.
`default_nettype none
module thi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_px,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_py,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_pz,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_ax,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_ay,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_az,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_bx,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_by_coord,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_bz,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_cx,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_cy,
  input  logic signed [thi_pkg::COORD_W-1:0]  in_cz,
  output logic                                push,
  output thi_pkg::item_t                      push_data,
  output thi_pkg::front_stat_t                stat
);

  logic signed [thi_pkg::COORD_W-1:0] pa [3];
  logic signed [thi_pkg::COORD_W-1:0] pb [3];
  logic signed [thi_pkg::COORD_W-1:0] pc [3];
  logic signed [thi_pkg::COORD_W-1:0] pp [3];

  logic signed [thi_pkg::EDGE_W-1:0]  e_nxt [3][3];
  logic signed [thi_pkg::EDGE_W-1:0]  e_r   [3][3];
  logic signed [thi_pkg::COORD_W-1:0] ay_r;
  logic                               s1_valid_r;

  logic [thi_pkg::EDGE_W-1:0]  mag_or;
  logic [thi_pkg::SHIFT_W-1:0] shift;
  thi_pkg::item_t              item_nxt;
  thi_pkg::item_t              item_r;
  logic                        s2_valid_r;

  assign pa[0] = in_ax; assign pa[1] = in_ay;       assign pa[2] = in_az;
  assign pb[0] = in_bx; assign pb[1] = in_by_coord; assign pb[2] = in_bz;
  assign pc[0] = in_cx; assign pc[1] = in_cy;       assign pc[2] = in_cz;
  assign pp[0] = in_px; assign pp[1] = in_py;       assign pp[2] = in_pz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_nxt[0][k] = thi_pkg::EDGE_W'(pc[k]) - thi_pkg::EDGE_W'(pa[k]);
      e_nxt[1][k] = thi_pkg::EDGE_W'(pb[k]) - thi_pkg::EDGE_W'(pa[k]);
      e_nxt[2][k] = thi_pkg::EDGE_W'(pp[k]) - thi_pkg::EDGE_W'(pa[k]);
    end
  end

  always_ff @(posedge clk) begin
    e_r  <= e_nxt;
    ay_r <= in_ay;
  end

  // one's complement magnitude of negatives matches the floor shift bound
  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        mag_or = mag_or | (e_r[i][k][thi_pkg::EDGE_W-1] ? ~e_r[i][k] : e_r[i][k]);
      end
    end
    shift = thi_pkg::scale_shift(mag_or);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        item_nxt.sc[i][k] = thi_pkg::SC_W'(e_r[i][k] >>> shift);
      end
    end
    item_nxt.e0y = e_r[0][1];
    item_nxt.e1y = e_r[1][1];
    item_nxt.ay  = ay_r;
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign push          = s2_valid_r;
  assign push_data     = item_r;
  assign stat.s1_valid = s1_valid_r;
  assign stat.s2_valid = s2_valid_r;

endmodule
`default_nettype wire

### hw/rtl/thi_fifo.sv
// Small register queue between front and back end.
// No dependencies.
`default_nettype none
module thi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign count    = count_r;

endmodule
`default_nettype wire

### hw/rtl/thi_div.sv
// Pipelined restoring divider for one barycentric weight, one quotient bit a stage.
// Depends on thi_pkg; weight magnitude saturates at 4.0.
`default_nettype none
module thi_div #(
  parameter int FRAC_BITS = thi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic signed [thi_pkg::PROD_W-1:0]  num,
  input  logic signed [thi_pkg::PROD_W-1:0]  den,
  output logic signed [FRAC_BITS+3:0]        weight
);

  localparam int N  = FRAC_BITS + 2;
  localparam int PW = thi_pkg::PROD_W;

  logic [PW-1:0] r_r   [N+1];
  logic [PW-1:0] d_r   [N+1];
  logic [N-1:0]  q_r   [N+1];
  logic          neg_r [N+1];
  logic          sat_r [N+1];

  logic [PW-1:0] rsh [N];
  logic [PW-1:0] dk  [N];
  logic          ge  [N];

  logic [PW-1:0] mag_in;
  logic [N:0]    mag_w;

  assign mag_in = num[PW-1] ? PW'(-num) : PW'(num);

  // two integer bits against 2*den then den, then fraction bits with shifted remainder
  always_comb begin
    for (int k = 0; k < N; k++) begin
      rsh[k] = (k >= 2) ? {r_r[k][PW-2:0], 1'b0} : r_r[k];
      dk[k]  = (k == 0) ? {d_r[k][PW-2:0], 1'b0} : d_r[k];
      ge[k]  = (rsh[k] >= dk[k]);
    end
  end

  always_ff @(posedge clk) begin
    r_r[0]   <= mag_in;
    d_r[0]   <= PW'(den);
    q_r[0]   <= '0;
    neg_r[0] <= num[PW-1];
    sat_r[0] <= (mag_in >= {den[PW-3:0], 2'b00});
    for (int k = 0; k < N; k++) begin
      r_r[k+1]   <= ge[k] ? rsh[k] - dk[k] : rsh[k];
      d_r[k+1]   <= d_r[k];
      q_r[k+1]   <= {q_r[k][N-2:0], ge[k]};
      neg_r[k+1] <= neg_r[k];
      sat_r[k+1] <= sat_r[k];
    end
  end

  assign mag_w  = sat_r[N] ? ((N+1)'(1) << N) : {1'b0, q_r[N]};
  assign weight = neg_r[N] ? -signed'({1'b0, mag_w}) : signed'({1'b0, mag_w});

endmodule
`default_nettype wire

### hw/rtl/thi_back.sv
// Back end: dot products, Gram determinant and numerators, two dividers,
// inside test and saturating height interpolation. Depends on thi_pkg, thi_div.
`default_nettype none
module thi_back #(
  parameter int FRAC_BITS = thi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  thi_pkg::item_t                     in_item,
  input  logic [thi_pkg::TOL_W-1:0]          tol,
  output logic                               out_valid,
  output logic                               out_inside_res,
  output logic signed [thi_pkg::COORD_W-1:0] out_height
);

  localparam int DIV_LAT = FRAC_BITS + 3;
  localparam int WT_W    = FRAC_BITS + 4;
  localparam int WC      = FRAC_BITS + 20;
  localparam int MW      = FRAC_BITS + 37;
  localparam int SH_W    = MW + 1 - FRAC_BITS;
  localparam int HW      = SH_W + 1;
  localparam int DW      = thi_pkg::DOT_W;
  localparam int PW      = thi_pkg::PROD_W;
  localparam int SW      = thi_pkg::SC_W;

  localparam logic signed [WC-1:0] ONE   = WC'(1) << FRAC_BITS;
  localparam logic signed [MW:0]   RND   = (MW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [HW-1:0] H_MAX = HW'(32'sh7FFF_FFFF);
  localparam logic signed [HW-1:0] H_MIN = HW'(32'sh8000_0000);

  typedef struct packed {
    logic signed [thi_pkg::EDGE_W-1:0]  e0y;
    logic signed [thi_pkg::EDGE_W-1:0]  e1y;
    logic signed [thi_pkg::COORD_W-1:0] ay;
  } base_t;

  typedef struct packed {
    logic  det_pos;
    base_t base;
  } side_t;

  function automatic logic signed [DW-1:0] dot3(input logic [2:0][SW-1:0] x,
                                                input logic [2:0][SW-1:0] y);
    logic signed [2*SW-1:0] p0, p1, p2;
    p0 = signed'(x[0]) * signed'(y[0]);
    p1 = signed'(x[1]) * signed'(y[1]);
    p2 = signed'(x[2]) * signed'(y[2]);
    return DW'(p0) + DW'(p1) + DW'(p2);
  endfunction

  // dot products
  logic signed [DW-1:0] d00_r, d01_r, d02_r, d11_r, d12_r;
  base_t                b1_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    d00_r <= dot3(in_item.sc[0], in_item.sc[0]);
    d01_r <= dot3(in_item.sc[0], in_item.sc[1]);
    d02_r <= dot3(in_item.sc[0], in_item.sc[2]);
    d11_r <= dot3(in_item.sc[1], in_item.sc[1]);
    d12_r <= dot3(in_item.sc[1], in_item.sc[2]);
    b1_r  <= '{e0y: in_item.e0y, e1y: in_item.e1y, ay: in_item.ay};
  end

  // products for determinant and numerators
  logic signed [PW-1:0] m_r [6];
  base_t                b2_r;
  logic                 v2_r;

  always_ff @(posedge clk) begin
    m_r[0] <= d00_r * d11_r;
    m_r[1] <= d01_r * d01_r;
    m_r[2] <= d11_r * d02_r;
    m_r[3] <= d01_r * d12_r;
    m_r[4] <= d00_r * d12_r;
    m_r[5] <= d01_r * d02_r;
    b2_r   <= b1_r;
  end

  logic signed [PW-1:0] det_r, nu_r, nv_r;
  base_t                b3_r;
  logic                 v3_r;

  always_ff @(posedge clk) begin
    det_r <= m_r[0] - m_r[1];
    nu_r  <= m_r[2] - m_r[3];
    nv_r  <= m_r[4] - m_r[5];
    b3_r  <= b2_r;
  end

  // dividers; sideband travels alongside
  logic signed [WT_W-1:0] u_w, v_w;

  thi_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk    (clk),
    .num    (nu_r),
    .den    (det_r),
    .weight (u_w)
  );

  thi_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk    (clk),
    .num    (nv_r),
    .den    (det_r),
    .weight (v_w)
  );

  side_t            line_r [DIV_LAT];
  logic [DIV_LAT-1:0] lv_r;

  always_ff @(posedge clk) begin
    line_r[0] <= '{det_pos: (det_r > 0), base: b3_r};
    for (int i = 1; i < DIV_LAT; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  // inside test and weighted edge heights
  side_t                  ls;
  logic signed [WC-1:0]   uc, vc, tolc;
  logic                   inside_nxt;
  logic                   inside5_r;
  logic signed [MW-1:0]   pu_r, pv_r;
  logic signed [thi_pkg::COORD_W-1:0] ay5_r;
  logic                   v5_r;

  assign ls   = line_r[DIV_LAT-1];
  assign uc   = WC'(u_w);
  assign vc   = WC'(v_w);
  assign tolc = WC'(signed'({1'b0, tol}));

  always_comb begin
    inside_nxt = ls.det_pos && (uc >= -tolc) && (vc >= -tolc) && (uc + vc <= ONE + tolc);
  end

  always_ff @(posedge clk) begin
    inside5_r <= inside_nxt;
    pu_r      <= u_w * ls.base.e0y;
    pv_r      <= v_w * ls.base.e1y;
    ay5_r     <= ls.base.ay;
  end

  // round half up to the coordinate format
  logic signed [MW:0]     sum_w;
  logic signed [SH_W-1:0] sh_r;
  logic signed [thi_pkg::COORD_W-1:0] ay6_r;
  logic                   inside6_r;
  logic                   v6_r;

  assign sum_w = (MW+1)'(pu_r) + (MW+1)'(pv_r) + RND;

  always_ff @(posedge clk) begin
    sh_r      <= SH_W'(sum_w >>> FRAC_BITS);
    ay6_r     <= ay5_r;
    inside6_r <= inside5_r;
  end

  // add base height and saturate
  logic signed [HW-1:0]               h_w;
  logic signed [thi_pkg::COORD_W-1:0] h_sat;
  logic                               out_valid_r, out_inside_r;
  logic signed [thi_pkg::COORD_W-1:0] out_height_r;

  assign h_w = HW'(sh_r) + HW'(ay6_r);

  always_comb begin
    if (h_w > H_MAX) begin
      h_sat = thi_pkg::COORD_W'(H_MAX);
    end else if (h_w < H_MIN) begin
      h_sat = thi_pkg::COORD_W'(H_MIN);
    end else begin
      h_sat = thi_pkg::COORD_W'(h_w);
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= inside6_r;
    out_height_r <= inside6_r ? h_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      lv_r        <= '0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      lv_r        <= {lv_r[DIV_LAT-2:0], v3_r};
      v5_r        <= lv_r[DIV_LAT-1];
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_height     = out_height_r;

endmodule
`default_nettype wire

### hw/rtl/triangle_height_interpolator_top.sv
// Throughput: one item per cycle while busy is low; the one-bit-a-stage weight dividers are pipelined.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// busy rises only while the front-to-back queue could overflow.
// Reset (rst_n low, synchronous) clears all valids and the queue and loads
// edge_tolerance with 7.
`default_nettype none
`include "triangle_height_interpolator_top_defines.svh"
module triangle_height_interpolator_top #(
  parameter int FRAC_BITS  = thi_pkg::FRAC_BITS_DEF,
  parameter int FIFO_DEPTH = thi_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [thi_pkg::COORD_W-1:0] in_px,
  input  logic signed [thi_pkg::COORD_W-1:0] in_py,
  input  logic signed [thi_pkg::COORD_W-1:0] in_pz,
  input  logic signed [thi_pkg::COORD_W-1:0] in_ax,
  input  logic signed [thi_pkg::COORD_W-1:0] in_ay,
  input  logic signed [thi_pkg::COORD_W-1:0] in_az,
  input  logic signed [thi_pkg::COORD_W-1:0] in_bx,
  input  logic signed [thi_pkg::COORD_W-1:0] in_by_coord,
  input  logic signed [thi_pkg::COORD_W-1:0] in_bz,
  input  logic signed [thi_pkg::COORD_W-1:0] in_cx,
  input  logic signed [thi_pkg::COORD_W-1:0] in_cy,
  input  logic signed [thi_pkg::COORD_W-1:0] in_cz,
  output logic                               out_valid,
  output logic                               out_inside_res,
  output logic signed [thi_pkg::COORD_W-1:0] out_height,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [thi_pkg::TOL_W-1:0]          cfg_edge_tolerance
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [thi_pkg::TOL_W-1:0] tol_r;
  logic                      accept;
  logic                      fifo_push, fifo_empty, fifo_full;
  thi_pkg::item_t            push_item, pop_item;
  logic [CW-1:0]             fifo_count;
  thi_pkg::front_stat_t      fstat;
  logic [CW:0]               inflight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= thi_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_edge_tolerance;
    end
  end

  // hold off while queued plus in-flight front words could fill the queue
  assign inflight = (CW+1)'(fifo_count) + (CW+1)'(fstat.s1_valid) + (CW+1)'(fstat.s2_valid);
  assign busy     = (inflight >= (CW+1)'(FIFO_DEPTH));
  assign accept   = start && !busy;

  thi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_px       (in_px),
    .in_py       (in_py),
    .in_pz       (in_pz),
    .in_ax       (in_ax),
    .in_ay       (in_ay),
    .in_az       (in_az),
    .in_bx       (in_bx),
    .in_by_coord (in_by_coord),
    .in_bz       (in_bz),
    .in_cx       (in_cx),
    .in_cy       (in_cy),
    .in_cz       (in_cz),
    .push        (fifo_push),
    .push_data   (push_item),
    .stat        (fstat)
  );

  thi_fifo #(
    .WIDTH (thi_pkg::ITEM_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (push_item),
    .pop       (!fifo_empty),
    .pop_data  (pop_item),
    .empty     (fifo_empty),
    .full      (fifo_full),
    .count     (fifo_count)
  );

  thi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (!fifo_empty),
    .in_item        (pop_item),
    .tol            (tol_r),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res),
    .out_height     (out_height)
  );

  `THI_ASSERT_IMP(a_outside_zero, out_valid && !out_inside_res, out_height == '0)
  `THI_ASSERT_IMP(a_queue_room, fifo_push, !fifo_full)
  `THI_ASSERT_NXT(a_front_take, accept, fstat.s1_valid)

endmodule
`default_nettype wire

### tb/tb_triangle_height_interpolator_top.sv
// Self-checking testbench for triangle_height_interpolator_top: point-in-triangle
// test and interpolated height, predicted in-bench. Depends on thi_pkg and the top.
`timescale 1ns / 1ps
module tb_triangle_height_interpolator_top;

  localparam int LATENCY = thi_pkg::FRAC_BITS_DEF + 11;
  localparam int FB      = thi_pkg::FRAC_BITS_DEF;

  typedef logic signed [thi_pkg::COORD_W-1:0] coord_t;
  typedef struct {
    coord_t v [12];   // px py pz ax ay az bx by bz cx cy cz
  } query_t;
  typedef struct {
    logic   hit;
    coord_t height;
  } height_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_c [12];
  logic out_valid, out_inside_res;
  coord_t out_height;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [thi_pkg::TOL_W-1:0] cfg_edge_tolerance = '0;

  query_t      pending_queries[$];
  height_res_t expected_heights[$];
  logic [thi_pkg::TOL_W-1:0] tol_model = thi_pkg::TOL_RESET;
  logic taken = 1'b0;
  bit   no_idle = 1'b0;
  int   errors = 0;
  int   n_inside = 0, n_outside = 0;

  initial for (int i = 0; i < 12; i++) in_c[i] = '0;

  always #10 clk = ~clk;

  triangle_height_interpolator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_px(in_c[0]), .in_py(in_c[1]), .in_pz(in_c[2]),
    .in_ax(in_c[3]), .in_ay(in_c[4]), .in_az(in_c[5]),
    .in_bx(in_c[6]), .in_by_coord(in_c[7]), .in_bz(in_c[8]),
    .in_cx(in_c[9]), .in_cy(in_c[10]), .in_cz(in_c[11]),
    .out_valid(out_valid), .out_inside_res(out_inside_res), .out_height(out_height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_edge_tolerance(cfg_edge_tolerance)
  );

  // num / den with FB fraction bits, truncated, magnitude saturated at 4.0
  function automatic longint bary_weight(longint num, longint den);
    longint unsigned mag, d, q, r;
    mag = (num < 0) ? -num : num;
    d = den;
    q = mag / d;
    if (q >= 4) begin
      q = 64'd4 << FB;
    end else begin
      r = mag % d;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic height_res_t interp_height(query_t q, logic [thi_pkg::TOL_W-1:0] tol);
    longint e [3][3];
    longint sc [3][3];
    longint m, mag, d00, d01, d02, d11, d12, det, u, v, eps, acc, h;
    int s;
    height_res_t r;
    r.hit = 1'b0;
    r.height = '0;
    m = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      e[0][k] = longint'(q.v[9+k]) - longint'(q.v[3+k]);
      e[1][k] = longint'(q.v[6+k]) - longint'(q.v[3+k]);
      e[2][k] = longint'(q.v[k])   - longint'(q.v[3+k]);
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        mag = (e[i][k] >= 0) ? e[i][k] : -e[i][k] - 1;
        if (mag > m) m = mag;
      end
    while ((m >> s) > thi_pkg::SC_LIMIT) s++;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) sc[i][k] = e[i][k] >>> s;
    d00 = sc[0][0]*sc[0][0] + sc[0][1]*sc[0][1] + sc[0][2]*sc[0][2];
    d01 = sc[0][0]*sc[1][0] + sc[0][1]*sc[1][1] + sc[0][2]*sc[1][2];
    d02 = sc[0][0]*sc[2][0] + sc[0][1]*sc[2][1] + sc[0][2]*sc[2][2];
    d11 = sc[1][0]*sc[1][0] + sc[1][1]*sc[1][1] + sc[1][2]*sc[1][2];
    d12 = sc[1][0]*sc[2][0] + sc[1][1]*sc[2][1] + sc[1][2]*sc[2][2];
    det = d00*d11 - d01*d01;
    if (det <= 0) return r;
    u = bary_weight(d11*d02 - d01*d12, det);
    v = bary_weight(d00*d12 - d01*d02, det);
    eps = tol;
    if (u >= -eps && v >= -eps && u + v <= (64'sd1 <<< FB) + eps) begin
      acc = u*e[0][1] + v*e[1][1];
      acc = (acc + (64'sd1 <<< (FB-1))) >>> FB;
      h = longint'(q.v[4]) + acc;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      r.hit = 1'b1;
      r.height = coord_t'(h);
    end
    return r;
  endfunction

  // driver: when the bus is free, present the next query, with random idle gaps unless no_idle is set
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (pending_queries.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
        query_t q;
        q = pending_queries.pop_front();
        for (int i = 0; i < 12; i++) in_c[i] <= q.v[i];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, compare each result word
  always @(posedge clk) begin
    taken = start && !busy && rst_n;
    if (taken) begin
      query_t q;
      for (int i = 0; i < 12; i++) q.v[i] = in_c[i];
      expected_heights.push_back(interp_height(q, tol_model));
    end
    if (rst_n && out_valid) begin
      if (expected_heights.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word inside=%0b height=%h",
                 $time, out_inside_res, out_height);
      end else begin
        height_res_t x;
        x = expected_heights.pop_front();
        if (x.hit) n_inside++; else n_outside++;
        if (out_inside_res !== x.hit) begin
          errors++;
          $display("%0t: inside mismatch expected %0b actual %0b",
                   $time, x.hit, out_inside_res);
        end
        if (out_height !== x.height) begin
          errors++;
          $display("%0t: height mismatch expected %h actual %h",
                   $time, x.height, out_height);
        end
      end
    end
  end

  task automatic add_query(input coord_t p0, p1, p2, a0, a1, a2,
                           b0, b1, b2, c0, c1, c2);
    query_t q;
    q.v = '{p0, p1, p2, a0, a1, a2, b0, b1, b2, c0, c1, c2};
    pending_queries.push_back(q);
  endtask

  function automatic coord_t rnd_at(int bits);
    longint x;
    x = $urandom;
    x = (x & ((64'd1 << bits) - 1)) - (64'd1 << (bits - 1));
    return coord_t'(x);
  endfunction

  // mostly triangles with a point near them; some degenerate, some pure noise
  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      int kind, bits, wu, wv;
      coord_t a [3], e0 [3], e1 [3], p [3];
      kind = $urandom_range(99);
      bits = $urandom_range(4, 30);
      wu = $urandom_range(0, 320) - 30;
      wv = $urandom_range(0, 320) - 30;
      for (int k = 0; k < 3; k++) begin
        a[k]  = rnd_at(bits);
        e0[k] = rnd_at(bits);
        e1[k] = (kind < 8) ? e0[k] * $signed($urandom_range(0, 3)) : rnd_at(bits);
        p[k]  = a[k] + coord_t'((longint'(e0[k]) * wu + longint'(e1[k]) * wv) >>> 8);
      end
      if ($urandom_range(1)) p[1] = $urandom;
      if (kind >= 88)
        add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        add_query(p[0], p[1], p[2], a[0], a[1], a[2], a[0] + e1[0], a[1] + e1[1],
                  a[2] + e1[2], a[0] + e0[0], a[1] + e0[1], a[2] + e0[2]);
    end
  endtask

  task automatic drain();
    wait (pending_queries.size() == 0 && !start && expected_heights.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [thi_pkg::TOL_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_edge_tolerance <= val;
    do @(posedge clk); while (!cfg_ready);
    tol_model = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  localparam coord_t ONE = 32'sh0001_0000;
  localparam coord_t MAXC = 32'sh7fff_ffff;
  localparam coord_t MINC = -32'sh7fff_ffff - 1;

  initial begin
    logic [thi_pkg::TOL_W-1:0] tols [5];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: triangle whose x-z projection is the unit triangle, a at origin, c on x, b on z
    add_query(0, 0, 0,       0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // at a
    add_query(ONE, 5, 0,     0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // at c
    add_query(0, 5, ONE,     0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // at b
    add_query(ONE/3, 0, ONE/3, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 0);        // center
    add_query(ONE/2, 0, ONE/2, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 0);        // on far edge
    add_query(-3, 0, ONE/2,  0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // just past edge
    add_query(-20, 0, ONE/2, 0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // beyond slack
    add_query(ONE, 0, ONE,   0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // outside
    add_query(5*ONE, 0, 0,   0, 0, 0,  0, ONE, ONE,  ONE, 2*ONE, 0);        // large weight
    // degenerate: all equal, collinear, b on a
    add_query(1, 2, 3, 7, 7, 7, 7, 7, 7, 7, 7, 7);
    add_query(0, 0, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);
    add_query(ONE, 0, ONE, 0, 0, 0, 0, 0, 0, ONE, 0, ONE);
    // coordinate extremes and height saturation
    add_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    add_query(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC);
    add_query(MINC, 0, MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC);
    add_query(MAXC, 0, MAXC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
    add_query(0, 0, 0, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC);
    add_query(0, 0, 0, MAXC, MINC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC);
    add_query(MAXC, 0, 0, MAXC - ONE, MAXC, 0, MAXC - ONE, MAXC, ONE, MAXC, MAXC, 0);
    drain();

    // sweep the tolerance, extremes included; one phase runs without gaps
    tols = '{17'd0, 17'd65536, 17'h1ffff, 17'd7, 17'd0};
    tols[4] = thi_pkg::TOL_W'($urandom_range(1, 2000));
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tols[ph]);
      add_query(-3, 0, ONE/2, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 0);
      add_query(ONE + 40, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 0);
      add_query(0, 0, 0, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC);
      no_idle = (ph == 2);
      add_random(85);
      drain();
    end
    no_idle = 1'b0;

    $display("Ran %0d results with tolerance at reset, zero, one, maximum and random values:",
             n_inside + n_outside);
    $display("  %0d inside, %0d outside or degenerate, %0d mismatches",
             n_inside, n_outside, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Verification failed");
    $finish;
  end

endmodule
